/* sv/rhir_pkg.sv */
// rhir_pkg: shared constants, types and helpers for the resampled history reader
// used by rhir_ctrl, rhir_dp and resampled_history_interp_reader_core
// no dependencies
`default_nettype none

package rhir_pkg;

    // ring depth, kept a power of two so ring positions wrap by truncation
    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int FRAC_W   = 8;
    localparam int POS_W    = ADDR_W + FRAC_W;

    localparam int VAL_W    = 16;
    localparam int TIME_W   = 20;
    localparam int AGO_W    = 18;
    localparam int DIFF_W   = VAL_W + 1;
    localparam int PROD_W   = DIFF_W + FRAC_W + 1;
    localparam int SUM_W    = PROD_W + 1;

    localparam logic [TIME_W-1:0] PERIOD_RESET = TIME_W'(16667);
    localparam logic [TIME_W-1:0] PERIOD_MIN   = TIME_W'(1000);
    localparam logic [TIME_W-1:0] PERIOD_MAX   = TIME_W'(1000000);
    localparam logic [TIME_W-1:0] ELAPSED_MAX  = TIME_W'(1000000);
    localparam logic [TIME_W-1:0] SLOT_EPS     = TIME_W'(100);

    // largest read distance, DEPTH-1 whole samples in Q.8
    localparam logic [AGO_W-1:0]  AGO_MAX      = AGO_W'((DEPTH - 1) * 256);

    // item kinds carried on tuser
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // configuration map
    localparam int   CFG_ADDR_W = 3;
    localparam logic [0:0] REG_PERIOD = 1'b0;

    typedef struct packed {
        logic clr_step;   // write zero at the clear pointer
        logic load;       // capture an accepted word
        logic add_step;   // one slot step of an add
        logic rd_pos;     // form ring position of a read
        logic rd_a;       // read first neighbor
        logic rd_b;       // read second neighbor
        logic rd_mul;     // difference times fraction
        logic rd_out;     // final sum into output register
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;   // clear pointer at last entry
        logic e_small;    // remaining time at or below the slot margin
    } dp_status_t;

    function automatic logic [TIME_W-1:0] period_clamp(input logic [TIME_W-1:0] p);
        logic [TIME_W-1:0] r;
        r = p;
        if (p < PERIOD_MIN) r = PERIOD_MIN;
        if (p > PERIOD_MAX) r = PERIOD_MAX;
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/rhir_ctrl.sv */
// rhir_ctrl: sequencer for clear, add stepping and the read pipeline
// depends on rhir_pkg
`default_nettype none

module rhir_ctrl
    import rhir_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic       s_action,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output dp_cmd_t         cmd,
    input  wire dp_status_t status
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_POS,
        ST_RD_A,
        ST_RD_B,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd          = '0;
        cmd.clr_step = (state_reg == ST_CLEAR);
        cmd.load     = accept;
        cmd.add_step = (state_reg == ST_ADD) && !status.e_small;
        cmd.rd_pos   = (state_reg == ST_POS);
        cmd.rd_a     = (state_reg == ST_RD_A);
        cmd.rd_b     = (state_reg == ST_RD_B);
        cmd.rd_mul   = (state_reg == ST_MUL);
        cmd.rd_out   = (state_reg == ST_OUT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            // a new result takes the slot, else a taken result frees it
            if ((state_reg == ST_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    if (status.clr_last) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) state_reg <= (s_action == ACT_READ) ? ST_POS : ST_ADD;
                end
                ST_ADD: begin
                    if (status.e_small) state_reg <= ST_IDLE;
                end
                ST_POS:  state_reg <= ST_RD_A;
                ST_RD_A: state_reg <= ST_RD_B;
                ST_RD_B: state_reg <= ST_MUL;
                ST_MUL:  state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_free) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/rhir_dp.sv */
// rhir_dp: history ring, slot timer, write index and interpolation arithmetic
// depends on rhir_pkg, driven by rhir_ctrl commands
`default_nettype none

module rhir_dp
    import rhir_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status,
    input  wire logic [TIME_W-1:0] period,
    input  wire logic [VAL_W-1:0]  sample_value,
    input  wire logic [TIME_W-1:0] elapsed_us,
    input  wire logic [AGO_W-1:0]  samples_ago,
    output logic [VAL_W-1:0]       read_value
);

    logic [VAL_W-1:0]         mem [DEPTH];
    logic [VAL_W-1:0]         rd_data_reg;

    logic [ADDR_W-1:0]        clr_cnt_reg;
    logic [ADDR_W-1:0]        wi_reg;
    logic [TIME_W-1:0]        ttn_reg;
    logic [TIME_W-1:0]        e_reg;
    logic [VAL_W-1:0]         val_reg;
    logic [POS_W-1:0]         ago_reg;
    logic [ADDR_W-1:0]        i_reg;
    logic [FRAC_W-1:0]        f_reg;
    logic signed [VAL_W-1:0]  a_val_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [VAL_W-1:0]         out_reg;

    // slot step
    logic signed [TIME_W:0]   d;
    logic [ADDR_W-1:0]        wi_next;
    logic [TIME_W-1:0]        ttn_next;
    logic [TIME_W-1:0]        e_next;

    // memory ports
    logic                     we;
    logic [ADDR_W-1:0]        wa;
    logic [VAL_W-1:0]         wd;
    logic [ADDR_W-1:0]        ra;

    // read arithmetic
    logic [POS_W-1:0]         pos;
    logic [ADDR_W-1:0]        j_idx;
    logic signed [DIFF_W-1:0] diff;
    logic signed [FRAC_W:0]   f_s;
    logic signed [SUM_W-1:0]  sum;

    // time left to the boundary minus time to spend, sign tells which ends first
    always_comb begin
        d = signed'({1'b0, ttn_reg}) - signed'({1'b0, e_reg});
        wi_next  = wi_reg;
        ttn_next = ttn_reg;
        e_next   = e_reg;
        priority if (d[TIME_W] || d == '0) begin
            // boundary reached with time to spare
            e_next   = e_reg - ttn_reg;
            ttn_next = period;
            wi_next  = wi_reg + 1'b1;
        end else if (d[TIME_W-1:0] < SLOT_EPS) begin
            // close enough to the boundary to take it
            e_next   = '0;
            ttn_next = d[TIME_W-1:0] + period;
            wi_next  = wi_reg + 1'b1;
        end else begin
            e_next   = '0;
            ttn_next = d[TIME_W-1:0];
        end
    end

    assign status.clr_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign status.e_small  = (e_reg <= SLOT_EPS);

    assign we = cmd.clr_step || cmd.add_step;
    assign wa = cmd.clr_step ? clr_cnt_reg : wi_next;
    assign wd = cmd.clr_step ? '0 : val_reg;

    assign pos   = {wi_reg, {FRAC_W{1'b0}}} - POS_W'(256) - ago_reg;
    assign j_idx = i_reg + 1'b1;
    assign ra    = cmd.rd_b ? j_idx : i_reg;

    always_ff @(posedge aclk) begin
        if (we) mem[wa] <= wd;
        rd_data_reg <= mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            wi_reg      <= '0;
            ttn_reg     <= PERIOD_RESET;
        end else begin
            if (cmd.clr_step) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.add_step) begin
                wi_reg  <= wi_next;
                ttn_reg <= ttn_next;
            end
        end
    end

    assign diff = signed'({rd_data_reg[VAL_W-1], rd_data_reg})
                - signed'({a_val_reg[VAL_W-1], a_val_reg});
    assign f_s  = signed'({1'b0, f_reg});
    assign sum  = signed'({{(SUM_W-VAL_W-FRAC_W){a_val_reg[VAL_W-1]}}, a_val_reg,
                           {FRAC_W{1'b0}}})
                + SUM_W'(prod_reg) + SUM_W'(128);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg <= sample_value;
            e_reg   <= (elapsed_us > ELAPSED_MAX) ? ELAPSED_MAX : elapsed_us;
            ago_reg <= POS_W'((samples_ago > AGO_MAX) ? AGO_MAX : samples_ago);
        end else if (cmd.add_step) begin
            e_reg <= e_next;
        end
        if (cmd.rd_pos) begin
            i_reg <= pos[POS_W-1:FRAC_W];
            f_reg <= pos[FRAC_W-1:0];
        end
        if (cmd.rd_b)   a_val_reg <= signed'(rd_data_reg);
        if (cmd.rd_mul) prod_reg  <= PROD_W'(diff * f_s);
        if (cmd.rd_out) out_reg   <= sum[VAL_W+FRAC_W-1:FRAC_W];
    end

    assign read_value = out_reg;

endmodule

`default_nettype wire

/* sv/resampled_history_interp_reader_core.sv */
// resampled_history_interp_reader_core: top level with config register and channels
// depends on rhir_pkg, rhir_ctrl, rhir_dp
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    tdata: sample_value, elapsed_us, samples_ago
//                                        tuser: action (0 add, 1 read)
//  m_*       out  m_tvalid / m_tready    tdata: read_value
//  apb       in   psel & penable         pwdata: sample_period_us at byte 0
//
//  after reset the ring is zeroed one entry a cycle, all DEPTH (1024) entries, no words taken
//  an add steps through the ring slots that it writes: the single
//    ring write port stores one slot a cycle
//  a read steps through the ring position, two ring reads over one port, one multiply, one sum
//  a finished read waits in the output register; a stall there holds the block
//    only once the next read reaches its last step
`default_nettype none

module resampled_history_interp_reader_core
    import rhir_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // input words
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [15:0] sample_value, [35:16] elapsed_us, [53:36] samples_ago, [55:54] zero
    input  wire logic [55:0]           s_tdata,
    // [0] action
    input  wire logic                  s_tuser,

    // result words
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [15:0] read_value
    output logic [15:0]                m_tdata,

    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] period_used;
    logic              reg_sel;
    dp_cmd_t           cmd;
    dp_status_t        status;

    // one register, selected by the word address
    assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_PERIOD);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(32-TIME_W){1'b0}}, period_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            period_reg <= pwdata[TIME_W-1:0];
        end
    end

    // out of range periods are pinned to the legal span
    assign period_used = period_clamp(period_reg);

    rhir_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    rhir_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .period       (period_used),
        .sample_value (s_tdata[15:0]),
        .elapsed_us   (s_tdata[35:16]),
        .samples_ago  (s_tdata[53:36]),
        .read_value   (m_tdata)
    );

`ifndef SYNTHESIS
    // one word at a time: the block is busy right after taking a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken on back to back cycles");

    // a result is loaded only from a busy read step
    a_result_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while idle");

    // an add never produces a result on the next cycle
    a_add_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == ACT_ADD) |=> !$rose(m_tvalid))
        else $error("add produced a result");

    // the ring clear after reset holds off input
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during ring clear");
`endif

endmodule

`default_nettype wire
